[sv/mva_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types and constants of the MIDI voice allocator.
// ----------------------------------------------------------------------------
package mva_pkg;

    localparam int VOICE_COUNT_DEF = 8;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CONTROL  = 4'hB;
    localparam logic [3:0] KIND_BEND     = 4'hE;

    localparam logic [6:0] CC_VOLUME     = 7'd7;
    localparam logic [6:0] VOLUME_FULL   = 7'd127;

    localparam logic [2:0] EV_IGNORED    = 3'd0;
    localparam logic [2:0] EV_ASSIGNED   = 3'd1;
    localparam logic [2:0] EV_NO_VOICE   = 3'd2;
    localparam logic [2:0] EV_RELEASED   = 3'd3;
    localparam logic [2:0] EV_UNMATCHED  = 3'd4;
    localparam logic [2:0] EV_CONTROL    = 3'd5;
    localparam logic [2:0] EV_BEND       = 3'd6;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] first_data;
        logic [6:0] second_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [2:0]  voice_index;
        logic [6:0]  note_number;
        logic [6:0]  velocity;
        logic [3:0]  channel;
        logic [6:0]  controller_number;
        logic [6:0]  controller_value;
        logic [13:0] bend_value;
        logic [6:0]  volume_level;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

[sv/mva_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_ctrl
// Sequencer: accept a message, scan the voice slots, commit the result.
// ----------------------------------------------------------------------------
module mva_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  mva_pkg::t_sts i_sts,
    output mva_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import mva_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SCAN;
            S_SCAN:   if (i_sts.scan_done) n_state = S_FINISH;
            S_FINISH: if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.commit = (r_state == S_FINISH) && i_sts.out_free;

endmodule

[sv/mva_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_datapath
// Message registers, voice slot store, slot scan and result register.
// ----------------------------------------------------------------------------
module mva_datapath #(
    parameter int VOICE_COUNT = mva_pkg::VOICE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mva_pkg::t_in_item  i_in_data,
    input  mva_pkg::t_cmd      i_cmd,
    input  logic               i_out_stall,
    output mva_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output mva_pkg::t_out_item o_out_data
);
    import mva_pkg::*;

    localparam int          IW   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam logic [IW-1:0] LAST = IW'(VOICE_COUNT - 1);

    logic [3:0]     r_kind;
    logic [3:0]     r_chan;
    logic [6:0]     r_d1;
    logic [6:0]     r_d2;

    logic [6:0]     r_note_mem [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] r_busy;
    logic [6:0]     r_volume;

    logic [IW-1:0]  r_raddr;
    logic [6:0]     r_rd_note;
    logic           r_rd_busy;
    logic [IW-1:0]  r_rd_idx;
    logic           r_rd_vld;

    logic           r_found;
    logic [IW-1:0]  r_slot;

    logic           r_out_valid;
    t_out_item      r_out_data;

    logic           is_on, is_off, is_note, hit, done;
    logic [6:0]     n_volume;
    logic [IW+2:0]  slot_ext;
    t_out_item      n_out;

    assign is_on   = (r_kind == KIND_NOTE_ON) && (r_d2 != 7'd0);
    assign is_off  = (r_kind == KIND_NOTE_OFF) || ((r_kind == KIND_NOTE_ON) && (r_d2 == 7'd0));
    assign is_note = is_on || is_off;

    assign hit  = is_on ? !r_rd_busy : (r_rd_busy && (r_rd_note == r_d1));
    assign done = !is_note || (r_rd_vld && (hit || (r_rd_idx == LAST)));

    assign o_sts.scan_done = done;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in_data.status_byte[7:4];
            r_chan <= i_in_data.status_byte[3:0];
            r_d1   <= i_in_data.first_data;
            r_d2   <= i_in_data.second_data;
        end
    end

    // registered slot read, one slot per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_note <= r_note_mem[r_raddr];
            r_rd_busy <= r_busy[r_raddr];
            r_rd_idx  <= r_raddr;
        end
        if (i_cmd.scan && done) begin
            r_found <= is_note && hit;
            r_slot  <= r_rd_idx;
        end
        if (i_cmd.commit && is_on && r_found) begin
            r_note_mem[r_slot] <= r_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raddr  <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_raddr  <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= 1'b1;
            if (r_raddr != LAST) r_raddr <= r_raddr + IW'(1);
        end
    end

    always_comb begin
        n_volume = r_volume;
        if ((r_kind == KIND_CONTROL) && (r_d1 == CC_VOLUME)) n_volume = r_d2;
    end

    assign slot_ext = {3'b000, r_slot};

    always_comb begin
        n_out              = '0;
        n_out.channel      = r_chan;
        n_out.volume_level = n_volume;
        n_out.event_code   = EV_IGNORED;
        if (is_on) begin
            n_out.note_number = r_d1;
            n_out.velocity    = r_d2;
            if (r_found) begin
                n_out.event_code  = EV_ASSIGNED;
                n_out.voice_index = slot_ext[2:0];
            end else begin
                n_out.event_code  = EV_NO_VOICE;
            end
        end else if (is_off) begin
            n_out.note_number = r_d1;
            if (r_found) begin
                n_out.event_code  = EV_RELEASED;
                n_out.voice_index = slot_ext[2:0];
            end else begin
                n_out.event_code  = EV_UNMATCHED;
            end
        end else if (r_kind == KIND_CONTROL) begin
            n_out.event_code        = EV_CONTROL;
            n_out.controller_number = r_d1;
            n_out.controller_value  = r_d2;
        end else if (r_kind == KIND_BEND) begin
            n_out.event_code = EV_BEND;
            n_out.bend_value = {r_d2, r_d1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_volume    <= VOLUME_FULL;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_volume    <= n_volume;
                r_out_valid <= 1'b1;
                if (is_note && r_found) r_busy[r_slot] <= is_on;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out_data <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[sv/midi_voice_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_voice_allocator
// First-free polyphonic voice allocation for MIDI channel messages.
//
// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_stall     i_in_data  (t_in_item)
// out      output     o_out_valid / i_out_stall   o_out_data (t_out_item)
//
// Note messages run the slot scan, one slot per cycle through the registered
// slot store up to the first hit or the last slot; other messages skip it.
// One message is in work at a time; the next transfer is taken once the
// result sits in the output register, even if that result is still stalled.
// Reset frees every voice and sets volume to full.
// ----------------------------------------------------------------------------
module midi_voice_allocator #(
    parameter int VOICE_COUNT = mva_pkg::VOICE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mva_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mva_pkg::t_out_item o_out_data
);
    import mva_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    mva_datapath #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[verif/tb_midi_voice_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_voice_allocator
// Self-checking bench for the first-free MIDI voice allocator.
//
// A directed script covers reset values, field extremes, every message kind,
// a full voice pool, repeated notes, zero-velocity release and unmatched
// note-off. Random traffic follows, mostly note-on/note-off pairs that hit
// held notes. It runs under four pacing phases, a long receiver hold-off
// that backs up the input, and sender pauses that drain all results.
// Each result is checked field by field against a fixed expectation or a
// behavioral model of the slot store and volume register.
// ----------------------------------------------------------------------------
module tb_midi_voice_allocator;
    import mva_pkg::*;

    localparam int VOICES           = VOICE_COUNT_DEF;
    localparam int MSG_LATENCY      = VOICES + 3;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int BURST_ITEMS      = 40;
    localparam int HOLD_CYCLES      = 300;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int PRINT_CAP        = 50;

    typedef struct packed {
        t_in_item  msg;
        logic      typed;
        t_out_item want;
    } t_script_row;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_msg    = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_event;

    // model of the voice pool
    logic [6:0] held_note [VOICES];
    logic       held_busy [VOICES];
    logic [6:0] volume_now;

    t_out_item   pending_events [$];
    t_script_row script_rows [$];

    int mismatches     = 0;
    int msgs_sent      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_granted   = 0;
    int hold_left      = 0;
    int event_seen [8];

    midi_voice_allocator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_msg),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_event)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_out_item next_voice_event(t_in_item m);
        t_out_item  ev;
        logic [3:0] kind;
        int         slot;
        ev          = '0;
        kind        = m.status_byte[7:4];
        ev.channel  = m.status_byte[3:0];
        slot        = -1;
        if (kind == KIND_NOTE_ON && m.second_data != 7'd0) begin
            ev.note_number = m.first_data;
            ev.velocity    = m.second_data;
            for (int i = 0; i < VOICES; i++) begin
                if (slot < 0 && !held_busy[i]) slot = i;
            end
            if (slot >= 0) begin
                held_busy[slot] = 1'b1;
                held_note[slot] = m.first_data;
                ev.event_code   = EV_ASSIGNED;
                ev.voice_index  = 3'(slot);
            end else begin
                ev.event_code = EV_NO_VOICE;
            end
        end else if (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) begin
            ev.note_number = m.first_data;
            for (int i = 0; i < VOICES; i++) begin
                if (slot < 0 && held_busy[i] && held_note[i] == m.first_data) slot = i;
            end
            if (slot >= 0) begin
                held_busy[slot] = 1'b0;
                ev.event_code   = EV_RELEASED;
                ev.voice_index  = 3'(slot);
            end else begin
                ev.event_code = EV_UNMATCHED;
            end
        end else if (kind == KIND_CONTROL) begin
            ev.event_code        = EV_CONTROL;
            ev.controller_number = m.first_data;
            ev.controller_value  = m.second_data;
            if (m.first_data == CC_VOLUME) volume_now = m.second_data;
        end else if (kind == KIND_BEND) begin
            ev.event_code = EV_BEND;
            ev.bend_value = {m.second_data, m.first_data};
        end else begin
            ev.event_code = EV_IGNORED;
        end
        ev.volume_level = volume_now;
        return ev;
    endfunction

    // expected result at full volume with no controller fields
    function automatic t_out_item early_event(logic [2:0] code, logic [2:0] vidx,
                                              logic [6:0] note, logic [6:0] vel,
                                              logic [3:0] chan, logic [13:0] bend);
        t_out_item ev;
        ev              = '0;
        ev.event_code   = code;
        ev.voice_index  = vidx;
        ev.note_number  = note;
        ev.velocity     = vel;
        ev.channel      = chan;
        ev.bend_value   = bend;
        ev.volume_level = VOLUME_FULL;
        return ev;
    endfunction

    task automatic add_row(logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                           logic typed, t_out_item want);
        t_script_row r;
        r.msg   = '{status_byte: st, first_data: d1, second_data: d2};
        r.typed = typed;
        r.want  = want;
        script_rows.push_back(r);
    endtask

    function automatic t_in_item random_msg();
        t_in_item m;
        int       pick;
        int       nbusy;
        int       which;
        logic [3:0] chan;
        pick  = $urandom_range(0, 99);
        chan  = 4'($urandom_range(0, 15));
        m     = '0;
        nbusy = 0;
        if (pick < 38) begin
            m.status_byte = {KIND_NOTE_ON, chan};
            m.first_data  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(56, 71));
            m.second_data = 7'($urandom_range(1, 127));
        end else if (pick < 72) begin
            m.first_data = 7'($urandom_range(56, 71));
            for (int i = 0; i < VOICES; i++) if (held_busy[i]) nbusy++;
            if (nbusy > 0 && $urandom_range(0, 99) < 85) begin
                which = $urandom_range(0, nbusy - 1);
                for (int i = 0; i < VOICES; i++) begin
                    if (held_busy[i]) begin
                        if (which == 0) m.first_data = held_note[i];
                        which--;
                    end
                end
            end
            if ($urandom_range(0, 1) == 0) begin
                m.status_byte = {KIND_NOTE_ON, chan};
                m.second_data = 7'd0;
            end else begin
                m.status_byte = {KIND_NOTE_OFF, chan};
                m.second_data = 7'($urandom_range(0, 127));
            end
        end else if (pick < 84) begin
            m.status_byte = {KIND_CONTROL, chan};
            m.first_data  = ($urandom_range(0, 2) == 0) ? CC_VOLUME
                                                        : 7'($urandom_range(0, 127));
            m.second_data = 7'($urandom_range(0, 127));
        end else if (pick < 92) begin
            m.status_byte = {KIND_BEND, chan};
            m.first_data  = 7'($urandom_range(0, 127));
            m.second_data = 7'($urandom_range(0, 127));
        end else begin
            m.status_byte = 8'($urandom_range(0, 255));
            m.first_data  = 7'($urandom_range(0, 127));
            m.second_data = 7'($urandom_range(0, 127));
        end
        return m;
    endfunction

    task automatic send_msg(t_in_item m, logic typed, t_out_item want);
        t_out_item ev;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_msg   <= m;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ev = next_voice_event(m);
        pending_events.push_back(typed ? want : ev);
        msgs_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_event(t_out_item got, t_out_item want);
        if (got.event_code !== want.event_code)
            report_mismatch("event_code", 64'(got.event_code), 64'(want.event_code));
        if (got.voice_index !== want.voice_index)
            report_mismatch("voice_index", 64'(got.voice_index), 64'(want.voice_index));
        if (got.note_number !== want.note_number)
            report_mismatch("note_number", 64'(got.note_number), 64'(want.note_number));
        if (got.velocity !== want.velocity)
            report_mismatch("velocity", 64'(got.velocity), 64'(want.velocity));
        if (got.channel !== want.channel)
            report_mismatch("channel", 64'(got.channel), 64'(want.channel));
        if (got.controller_number !== want.controller_number)
            report_mismatch("controller_number", 64'(got.controller_number),
                            64'(want.controller_number));
        if (got.controller_value !== want.controller_value)
            report_mismatch("controller_value", 64'(got.controller_value),
                            64'(want.controller_value));
        if (got.bend_value !== want.bend_value)
            report_mismatch("bend_value", 64'(got.bend_value), 64'(want.bend_value));
        if (got.volume_level !== want.volume_level)
            report_mismatch("volume_level", 64'(got.volume_level), 64'(want.volume_level));
    endtask

    // result side: check each transfer against the oldest expectation
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected result", 64'(out_event), '0);
            end else begin
                want = pending_events.pop_front();
                check_event(out_event, want);
                event_seen[want.event_code]++;
            end
        end
    end

    // result side stall, with an occasional long hold-off
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (hold_granted != hold_asked) begin
            hold_granted++;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("midi_voice_allocator regression: fail");
        $finish;
    end

    initial begin
        int idle_plan [4][2];
        idle_plan = '{'{0, 0}, '{70, 0}, '{0, 70}, '{21, 21}};
        foreach (event_seen[i]) event_seen[i] = 0;
        for (int i = 0; i < VOICES; i++) begin
            held_note[i] = 7'd0;
            held_busy[i] = 1'b0;
        end
        volume_now = VOLUME_FULL;

        add_row(8'h00, 7'h7F, 7'h7F, 1'b1, early_event(EV_IGNORED, 3'd0, 7'd0, 7'd0, 4'h0, 14'd0));
        add_row(8'hFF, 7'h00, 7'h00, 1'b1, early_event(EV_IGNORED, 3'd0, 7'd0, 7'd0, 4'hF, 14'd0));
        add_row(8'hE3, 7'h00, 7'h00, 1'b1, early_event(EV_BEND, 3'd0, 7'd0, 7'd0, 4'h3, 14'd0));
        add_row(8'hEF, 7'h7F, 7'h7F, 1'b1,
                early_event(EV_BEND, 3'd0, 7'd0, 7'd0, 4'hF, 14'h3FFF));
        add_row(8'h80, 7'd60, 7'd64, 1'b1,
                early_event(EV_UNMATCHED, 3'd0, 7'd60, 7'd0, 4'h0, 14'd0));
        add_row(8'h90, 7'd0, 7'd127, 1'b1,
                early_event(EV_ASSIGNED, 3'd0, 7'd0, 7'd127, 4'h0, 14'd0));
        add_row(8'h9F, 7'd127, 7'd1, 1'b1,
                early_event(EV_ASSIGNED, 3'd1, 7'd127, 7'd1, 4'hF, 14'd0));
        // fill the pool, same note held twice
        add_row(8'h95, 7'd60, 7'd100, 1'b0, '0);
        add_row(8'h92, 7'd60, 7'd90, 1'b0, '0);
        add_row(8'h90, 7'd10, 7'd50, 1'b0, '0);
        add_row(8'h91, 7'd20, 7'd51, 1'b0, '0);
        add_row(8'h93, 7'd30, 7'd52, 1'b0, '0);
        add_row(8'h94, 7'd40, 7'd53, 1'b0, '0);
        add_row(8'h9A, 7'd5, 7'd100, 1'b0, '0);
        // zero-velocity release, then note-off on the second copy, then none left
        add_row(8'h90, 7'd60, 7'd0, 1'b0, '0);
        add_row(8'h8C, 7'd60, 7'd0, 1'b0, '0);
        add_row(8'h80, 7'd60, 7'd0, 1'b0, '0);
        add_row(8'h97, 7'd61, 7'd33, 1'b0, '0);
        add_row(8'hB0, CC_VOLUME, 7'd0, 1'b0, '0);
        add_row(8'hBF, 7'd127, 7'd127, 1'b0, '0);
        add_row(8'hB0, CC_VOLUME, 7'd127, 1'b0, '0);
        add_row(8'hA5, 7'd1, 7'd2, 1'b0, '0);
        add_row(8'hC0, 7'd3, 7'd4, 1'b0, '0);
        add_row(8'hD0, 7'd5, 7'd6, 1'b0, '0);
        add_row(8'h7F, 7'd9, 7'd9, 1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[i])
            send_msg(script_rows[i].msg, script_rows[i].typed, script_rows[i].want);
        drain_results();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_plan[p][0];
            recv_stall_pct = idle_plan[p][1];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) send_msg(random_msg(), 1'b0, '0);
            if (p == 0) begin
                // long receiver hold-off while the sender keeps offering
                hold_asked++;
                for (int n = 0; n < BURST_ITEMS; n++) send_msg(random_msg(), 1'b0, '0);
            end
            drain_results();
        end

        repeat (4 * MSG_LATENCY) @(posedge clk);

        $display("covered %0d messages over four pacing phases, one long output hold-off",
                 msgs_sent);
        $display("assigned %0d, no voice %0d, released %0d, unmatched %0d,",
                 event_seen[EV_ASSIGNED], event_seen[EV_NO_VOICE], event_seen[EV_RELEASED],
                 event_seen[EV_UNMATCHED]);
        $display("control %0d, bend %0d, ignored %0d",
                 event_seen[EV_CONTROL], event_seen[EV_BEND], event_seen[EV_IGNORED]);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("midi_voice_allocator regression: pass");
        end else begin
            $display("mismatches: %0d, results missing: %0d", mismatches,
                     pending_events.size());
            $display("midi_voice_allocator regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
sv/mva_pkg.sv
sv/mva_ctrl.sv
sv/mva_datapath.sv
sv/midi_voice_allocator.sv
verif/tb_midi_voice_allocator.sv
